@@ hw/rtl/sup_pkg.sv @@
// sup_pkg: types, character codes and digit decode shared by the
// string-to-unsigned parser. No dependencies.
`default_nettype none

package sup_pkg;

	typedef enum logic [1:0] {
		PH_SKIP,
		PH_ZERO,
		PH_DIGITS,
		PH_STOP
	} scan_phase_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [5:0] BASE_RESET = 6'd10;
	localparam logic [5:0] RADIX_DEC  = 6'd10;
	localparam logic [5:0] RADIX_HEX  = 6'd16;
	localparam logic [5:0] BASE_AUTO  = 6'd0;
	localparam logic [4:0] DIGIT_NONE = 5'd16;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] end_offset;
	} res_item_t;

	// scan stage to result register
	typedef struct packed {
		logic      fire;
		res_item_t item;
	} scan_res_t;

	// 0..15 for a hex digit, DIGIT_NONE otherwise
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		begin
			d = DIGIT_NONE;
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = 5'(c - CH_ZERO);
			end else if (c >= CH_LA && c <= CH_LF) begin
				d = 5'(c - CH_LA + 8'd10);
			end else if (c >= CH_UA && c <= CH_UF) begin
				d = 5'(c - CH_UA + 8'd10);
			end
			return d;
		end
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sup_scan.sv @@
// sup_scan: per-string scan state and the one-character update
// (whitespace, 0x prefix, digit accumulate). Uses sup_pkg.
`default_nettype none

module sup_scan #(
	parameter int OFFSET_WIDTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire sup_pkg::char_item_t item,
	input  wire [5:0]                base,
	output sup_pkg::scan_res_t       res
);

	sup_pkg::scan_phase_t    phase_q, phase_nxt;
	logic [5:0]              radix_q, radix_nxt;
	logic [63:0]             acc_q, acc_nxt;
	logic [OFFSET_WIDTH-1:0] pos_q, pos_nxt, pos_inc;
	logic [OFFSET_WIDTH+15:0] pos_ext;

	logic       is_ws, is_x, zero_pref, take, ok;
	logic [4:0] dig;
	logic [5:0] base_sel, rad;

	always_comb begin
		dig       = sup_pkg::digit_of(item.character);
		is_ws     = (item.character == sup_pkg::CH_SPACE) ||
		            (item.character == sup_pkg::CH_TAB);
		is_x      = (item.character == sup_pkg::CH_LX) ||
		            (item.character == sup_pkg::CH_UX);
		zero_pref = ((base == sup_pkg::BASE_AUTO) || (base == sup_pkg::RADIX_HEX)) &&
		            (item.character == sup_pkg::CH_ZERO);
		base_sel  = (base == sup_pkg::BASE_AUTO) ? sup_pkg::RADIX_DEC : base;
		rad       = (phase_q == sup_pkg::PH_DIGITS) ? radix_q : base_sel;
		ok        = (dig != sup_pkg::DIGIT_NONE) && ({1'b0, dig} < rad);
		pos_inc   = (pos_q == {OFFSET_WIDTH{1'b1}}) ? pos_q : pos_q + OFFSET_WIDTH'(1);
		case (phase_q)
			sup_pkg::PH_SKIP:   take = !is_ws && !zero_pref;
			sup_pkg::PH_ZERO:   take = !is_x;
			sup_pkg::PH_DIGITS: take = 1'b1;
			default:            take = 1'b0;
		endcase
	end

	// next phase
	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			sup_pkg::PH_SKIP: begin
				if (zero_pref && !is_ws) begin
					phase_nxt = sup_pkg::PH_ZERO;
				end else if (!is_ws) begin
					phase_nxt = ok ? sup_pkg::PH_DIGITS : sup_pkg::PH_STOP;
				end
			end
			sup_pkg::PH_ZERO: begin
				if (is_x || ok) begin
					phase_nxt = sup_pkg::PH_DIGITS;
				end else begin
					phase_nxt = sup_pkg::PH_STOP;
				end
			end
			sup_pkg::PH_DIGITS: begin
				if (!ok) begin
					phase_nxt = sup_pkg::PH_STOP;
				end
			end
			default: phase_nxt = phase_q;
		endcase
	end

	// datapath
	always_comb begin
		radix_nxt = radix_q;
		acc_nxt   = acc_q;
		pos_nxt   = pos_q;
		if (take) begin
			radix_nxt = rad;
			if (ok) begin
				acc_nxt = acc_q * {58'd0, rad} + {59'd0, dig};
				pos_nxt = pos_inc;
			end
		end else if (phase_q == sup_pkg::PH_ZERO) begin
			radix_nxt = sup_pkg::RADIX_HEX;
			pos_nxt   = pos_inc;
		end else if (phase_q == sup_pkg::PH_SKIP) begin
			pos_nxt   = pos_inc;
		end
		// a stopped scan no longer counts, so the position is the stop point
		pos_ext             = {16'd0, pos_nxt};
		res.fire            = en && item.last;
		res.item.value      = acc_nxt;
		res.item.end_offset = pos_ext[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sup_pkg::PH_SKIP;
			radix_q <= '0;
			acc_q   <= '0;
			pos_q   <= '0;
		end else if (en) begin
			if (item.last) begin
				phase_q <= sup_pkg::PH_SKIP;
				radix_q <= '0;
				acc_q   <= '0;
				pos_q   <= '0;
			end else begin
				phase_q <= phase_nxt;
				radix_q <= radix_nxt;
				acc_q   <= acc_nxt;
				pos_q   <= pos_nxt;
			end
		end
	end

`ifndef ASSERT_OFF
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |=> (phase_q == sup_pkg::PH_SKIP) && (pos_q == '0) && (acc_q == '0))
		else $error("scan state not cleared after result");
	a_radix_set: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == sup_pkg::PH_DIGITS) |-> (radix_q != '0))
		else $error("digit phase with zero radix");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/sup_out_reg.sv @@
// sup_out_reg: result register with valid/stall toward the consumer.
// Uses sup_pkg.
`default_nettype none

module sup_out_reg (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire sup_pkg::scan_res_t res,
	output logic                    res_valid,
	output sup_pkg::res_item_t      res_item,
	input  wire                     res_stall
);

	logic               valid_q;
	sup_pkg::res_item_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.fire) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			item_q <= res.item;
		end
	end

	assign res_valid = valid_q;
	assign res_item  = item_q;

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.fire |-> !(valid_q && res_stall))
		else $error("result item overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/string_to_unsigned_parser.sv @@
// string_to_unsigned_parser: top level; input register, base register,
// scan stage (sup_scan) and result register (sup_out_reg). Uses sup_pkg.
//
//   channel  | signals                          | dir | item
//   char     | char_valid, char_item, char_stall | in  | one character + last flag
//   res      | res_valid, res_item, res_stall    | out | value + end_offset
//   cfg      | cfg_valid, cfg_ready, cfg_data    | in  | base register write
//
// One character per cycle unless a last item waits; the scan state updates in a
// single 64x6 multiply-add. Each result passes the input and result registers.
// Reset sets base to 10 and clears the scan; cfg_ready is always high.
// Only a last item waits in the input register while an earlier result is stalled;
// other characters keep flowing.
`default_nettype none

module string_to_unsigned_parser #(
	parameter int OFFSET_WIDTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      char_valid,
	input  wire sup_pkg::char_item_t char_item,
	output logic                     char_stall,
	output logic                     res_valid,
	output sup_pkg::res_item_t       res_item,
	input  wire                      res_stall,
	input  wire                      cfg_valid,
	output logic                     cfg_ready,
	input  wire [5:0]                cfg_data
);

	logic                valid_s1;
	sup_pkg::char_item_t item_s1;
	logic [5:0]          base_q;
	logic                adv;
	sup_pkg::scan_res_t  scan_res;

	assign cfg_ready  = 1'b1;
	assign adv        = valid_s1 && (!item_s1.last || !res_valid || !res_stall);
	assign char_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= sup_pkg::BASE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			item_s1 <= char_item;
		end
	end

	sup_scan #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.base   (base_q),
		.res    (scan_res)
	);

	sup_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (scan_res),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_stall (res_stall)
	);

`ifndef ASSERT_OFF
	a_plain_char_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !item_s1.last) |-> !char_stall)
		else $error("non-last item held in input register");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for string_to_unsigned_parser. Streams strings through
// the char channel, tracks the expected value/offset per string and checks each result.
// Depends on sup_pkg and the string_to_unsigned_parser RTL only.
`default_nettype none

module tb_top;

	// Tracks the parse state per accepted item and holds the numbers still due.
	class number_parse_tracker;
		logic [5:0]           base;
		sup_pkg::scan_phase_t phase;
		logic [5:0]           radix;
		logic [63:0]          acc;
		logic [15:0]          pos;
		logic [15:0]          stop_pos;
		sup_pkg::res_item_t   expected_numbers[$];
		int                   mismatches;

		function new();
			base = sup_pkg::BASE_RESET;
			mismatches = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = sup_pkg::PH_SKIP;
			radix = '0;
			acc = '0;
			pos = '0;
			stop_pos = '0;
		endfunction

		function logic [4:0] char_digit(logic [7:0] c);
			if (c >= sup_pkg::CH_ZERO && c <= sup_pkg::CH_NINE)
				return 5'(c - sup_pkg::CH_ZERO);
			if (c >= sup_pkg::CH_LA && c <= sup_pkg::CH_LF)
				return 5'(c - sup_pkg::CH_LA + 8'd10);
			if (c >= sup_pkg::CH_UA && c <= sup_pkg::CH_UF)
				return 5'(c - sup_pkg::CH_UA + 8'd10);
			return sup_pkg::DIGIT_NONE;
		endfunction

		function void bump();
			if (pos != 16'hFFFF) pos = pos + 16'd1;
		endfunction

		function void take_digit(logic [7:0] c);
			logic [4:0] d;
			d = char_digit(c);
			if (d >= sup_pkg::DIGIT_NONE || {1'b0, d} >= radix) begin
				stop_pos = pos;
				phase = sup_pkg::PH_STOP;
			end else begin
				acc = acc * 64'(radix) + 64'(d);
				bump();
			end
		endfunction

		function logic [5:0] start_radix();
			return (base == sup_pkg::BASE_AUTO) ? sup_pkg::RADIX_DEC : base;
		endfunction

		function void take_char(sup_pkg::char_item_t it);
			logic [7:0]         c;
			sup_pkg::res_item_t r;
			c = it.character;
			case (phase)
				sup_pkg::PH_SKIP: begin
					if (c == sup_pkg::CH_SPACE || c == sup_pkg::CH_TAB) begin
						bump();
					end else if ((base == sup_pkg::BASE_AUTO ||
					              base == sup_pkg::RADIX_HEX) &&
					             c == sup_pkg::CH_ZERO) begin
						bump();
						phase = sup_pkg::PH_ZERO;
					end else begin
						radix = start_radix();
						phase = sup_pkg::PH_DIGITS;
						take_digit(c);
					end
				end
				sup_pkg::PH_ZERO: begin
					if (c == sup_pkg::CH_LX || c == sup_pkg::CH_UX) begin
						bump();
						radix = sup_pkg::RADIX_HEX;
						phase = sup_pkg::PH_DIGITS;
					end else begin
						// pending zero is a digit, acc stays 0
						radix = start_radix();
						phase = sup_pkg::PH_DIGITS;
						take_digit(c);
					end
				end
				sup_pkg::PH_DIGITS: take_digit(c);
				default: ;
			endcase
			if (it.last) begin
				r.value = acc;
				r.end_offset = (phase == sup_pkg::PH_STOP) ? stop_pos : pos;
				expected_numbers.push_back(r);
				clear_scan();
			end
		endfunction

		task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			mismatches++;
		endtask

		task check_number(sup_pkg::res_item_t got);
			sup_pkg::res_item_t want;
			if (expected_numbers.size() == 0) begin
				flag_mismatch("unexpected result, value", got.value, 64'd0);
			end else begin
				want = expected_numbers.pop_front();
				if (got.value !== want.value)
					flag_mismatch("value", got.value, want.value);
				if (got.end_offset !== want.end_offset)
					flag_mismatch("end_offset", 64'(got.end_offset), 64'(want.end_offset));
			end
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                char_valid = 1'b0;
	sup_pkg::char_item_t char_item = '0;
	logic                char_stall;
	logic                res_valid;
	sup_pkg::res_item_t  res_item;
	logic                res_stall = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [5:0]          cfg_data = '0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	number_parse_tracker tracker = new();

	logic [5:0] base_plan [0:11] = '{6'd0, 6'd16, 6'd10, 6'd36,
		6'd63, 6'd1, 6'd2, 6'd0, 6'd16, 6'd8, 6'd7, 6'd10};

	string_to_unsigned_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_item (char_item),
		.char_stall(char_stall),
		.res_valid (res_valid),
		.res_item  (res_item),
		.res_stall (res_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: random stall, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// all handshakes are sampled mid-cycle; everything moves on the rising edge
	always @(negedge clk) begin
		if (arst_n && res_valid && !res_stall)
			tracker.check_number(res_item);
	end

	task automatic send_char(logic [7:0] c, logic lst);
		bit took;
		if ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{c, lst};
		do begin
			@(negedge clk);
			took = !char_stall;
			@(posedge clk);
		end while (!took);
		tracker.take_char('{c, lst});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic drain();
		char_valid <= 1'b0;
		while (tracker.expected_numbers.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_base(logic [5:0] b);
		bit took;
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= b;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		tracker.base = b;
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) return sup_pkg::CH_ZERO + 8'(d);
		return ($urandom_range(1) ? sup_pkg::CH_UA : sup_pkg::CH_LA) + 8'(d - 10);
	endfunction

	// one string; returns its item count, the random tail appended after it not counted
	task automatic send_random_string(output int used);
		logic [7:0] str_q[$];
		int         r;
		int         top;
		if ($urandom_range(99) < 20) begin
			repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom));
			used = str_q.size();
		end else begin
			repeat ($urandom_range(0, 3))
				str_q.push_back($urandom_range(1) ? sup_pkg::CH_SPACE : sup_pkg::CH_TAB);
			r = (tracker.base == sup_pkg::BASE_AUTO) ? 10 : tracker.base;
			if ((tracker.base == sup_pkg::BASE_AUTO || tracker.base == sup_pkg::RADIX_HEX) &&
			    $urandom_range(2) != 0) begin
				str_q.push_back(sup_pkg::CH_ZERO);
				str_q.push_back($urandom_range(1) ? sup_pkg::CH_LX : sup_pkg::CH_UX);
				r = 16;
			end
			top = (r > 16) ? 16 : r;
			repeat ($urandom_range(0, 22)) str_q.push_back(digit_char($urandom_range(0, top - 1)));
			case ($urandom_range(2))
				0: ;
				1: str_q.push_back(8'h00);
				default: str_q.push_back(8'($urandom));
			endcase
			used = str_q.size();
			repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom));
			if (str_q.size() == 0) begin
				str_q.push_back(8'($urandom));
				used = 1;
			end
		end
		foreach (str_q[i])
			send_char(str_q[i], i == str_q.size() - 1);
	endtask

	initial begin
		int used;
		int seg_items;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset base first
		send_text("\t 12a");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		set_base(sup_pkg::BASE_AUTO);
		send_text("0x1F");
		send_text("0");
		send_text("07");
		send_text("0X");
		set_base(sup_pkg::RADIX_HEX);
		send_text("0xg");
		set_base(6'd36);
		send_text("fg");
		set_base(6'd1);
		send_text("01");

		for (int p = 0; p < 3; p++) begin
			drain();
			send_idle_pct = (p == 0) ? 13 : (p == 1) ? 74 : 0;
			recv_idle_pct <= (p == 0) ? 74 : (p == 1) ? 13 : 0;
			if (p == 2) begin
				// long receiver hold-off while strings keep coming, so the input backs up
				set_base(sup_pkg::RADIX_DEC);
				send_text("123q");
				hold_req <= hold_req + 1;
				repeat (3) send_random_string(used);
			end
			for (int s = 0; s < 4; s++) begin
				set_base(base_plan[p * 4 + s]);
				seg_items = 0;
				while (seg_items < 90) begin
					send_random_string(used);
					seg_items += used;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.expected_numbers.size() != 0)
			tracker.flag_mismatch("results still due",
				64'(tracker.expected_numbers.size()), 64'd0);
		if (tracker.mismatches == 0)
			$display("** string_to_unsigned_parser: PASSED **");
		else
			$display("** string_to_unsigned_parser: FAILED **");
		$finish;
	end

	initial begin
		#36_000_000;
		$display("** string_to_unsigned_parser: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
